### rtl/cahv_point_projection_assert.svh
// Assertion macros shared by the projection block.
`ifndef CAHV_POINT_PROJECTION_ASSERT_SVH
`define CAHV_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CAHV_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CAHV_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cahv_pkg.sv
package cahv_pkg;

    localparam int CW    = 48;
    localparam int DW    = 58;
    localparam int PW    = 108;
    localparam int NW    = PW + 16;
    localparam int QW    = 32;
    localparam int SW    = PW + QW;
    localparam int PPW   = 55;
    localparam int CLW   = 24;
    localparam int DLW   = 29;
    localparam int NCOEF = 12;

    localparam int C_BASE = 0;
    localparam int A_BASE = 3;
    localparam int H_BASE = 6;
    localparam int V_BASE = 9;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam logic signed [7:0] FOV_MIN = 8'sd1;

    typedef logic signed [CW-1:0]  coef_t;
    typedef logic signed [DW-1:0]  dvec_t;
    typedef logic signed [PW-1:0]  dot_t;
    typedef logic signed [PPW-1:0] part_t;
    typedef logic        [PW-1:0]  mag_t;
    typedef logic        [NW-1:0]  num_t;
    typedef logic        [QW-1:0]  quo_t;

    typedef struct packed {
        logic vld;
        logic ok;
    } ctl_t;

    typedef struct packed {
        logic vld;
        logic ok;
        logic neg_x;
        logic neg_y;
    } div_ctl_t;

endpackage

### rtl/cahv_point_projection.sv
// A projected point passes the input, multiplier, s5, divider and output registers.
// Throughput: one word per cycle while not stalled; the 32 restoring divider stages set the depth.
// The whole pipeline stalls only while a finished result waits on m_tready.
// Reset (aresetn low, synchronous) clears every valid bit and the coefficient table.
// A load word with an index below 12 writes the table at once; no load word produces a result.
`include "cahv_point_projection_assert.svh"

module cahv_point_projection (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index, coef_value, northing, easting, elevation, fov_mask, zero fill
    input  logic [175:0] s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // image_x, image_y
    output logic [63:0]  m_tdata,
    // valid_res, saturated
    output logic [1:0]   m_tuser
);

    localparam int QW = cahv_pkg::QW;

    logic                en, accept;
    logic [3:0]          ld_idx;
    cahv_pkg::coef_t     coef_reg [cahv_pkg::NCOEF];

    cahv_pkg::ctl_t      s1_ctl_reg;
    cahv_pkg::dvec_t     d_reg [3];
    cahv_pkg::dvec_t     d_next [3];
    cahv_pkg::coef_t     cf_reg [9];

    cahv_pkg::ctl_t      mul_ctl;
    cahv_pkg::dot_t      dot [3];

    cahv_pkg::div_ctl_t  s5_ctl_reg, s5_ctl_next;
    cahv_pkg::mag_t      mag_a_reg, mag_a_next, mag_h, mag_v;
    cahv_pkg::num_t      num_x_reg, num_y_reg;

    cahv_pkg::div_ctl_t  div_ctl;
    cahv_pkg::quo_t      q_x, q_y;
    logic                ovf_x, ovf_y;

    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;
    assign ld_idx   = s_tdata[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cahv_pkg::NCOEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (accept && s_tuser == cahv_pkg::CMD_LOAD
                     && ld_idx < 4'(cahv_pkg::NCOEF)) begin
            coef_reg[ld_idx] <= s_tdata[51:4];
        end
    end

    always_comb begin
        logic [39:0] n, e;
        logic [31:0] z;
        cahv_pkg::coef_t c0, c1, c2;
        n  = s_tdata[91:52];
        e  = s_tdata[131:92];
        z  = s_tdata[163:132];
        c0 = coef_reg[cahv_pkg::C_BASE];
        c1 = coef_reg[cahv_pkg::C_BASE + 1];
        c2 = coef_reg[cahv_pkg::C_BASE + 2];
        d_next[0] = {{2{n[39]}}, n, 16'd0} - {{10{c0[47]}}, c0};
        d_next[1] = {{2{e[39]}}, e, 16'd0} - {{10{c1[47]}}, c1};
        d_next[2] = {cahv_pkg::DW{1'b0}} - {{10{z[31]}}, z, 16'd0} - {{10{c2[47]}}, c2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg.vld <= accept && s_tuser == cahv_pkg::CMD_PROJECT;
            s1_ctl_reg.ok  <= $signed(s_tdata[171:164]) > cahv_pkg::FOV_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
            for (int j = 0; j < 9; j++) begin
                cf_reg[j] <= coef_reg[cahv_pkg::A_BASE + j];
            end
        end
    end

    cahv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (s1_ctl_reg),
        .d       (d_reg),
        .cf      (cf_reg),
        .out_ctl (mul_ctl),
        .dot     (dot)
    );

    always_comb begin
        s5_ctl_next.vld   = mul_ctl.vld;
        s5_ctl_next.ok    = mul_ctl.ok && (dot[0] != '0);
        s5_ctl_next.neg_x = dot[1][cahv_pkg::PW-1] ^ dot[0][cahv_pkg::PW-1];
        s5_ctl_next.neg_y = dot[2][cahv_pkg::PW-1] ^ dot[0][cahv_pkg::PW-1];
        mag_a_next = dot[0][cahv_pkg::PW-1] ? cahv_pkg::mag_t'(-dot[0])
                                            : cahv_pkg::mag_t'(dot[0]);
        mag_h      = dot[1][cahv_pkg::PW-1] ? cahv_pkg::mag_t'(-dot[1])
                                            : cahv_pkg::mag_t'(dot[1]);
        mag_v      = dot[2][cahv_pkg::PW-1] ? cahv_pkg::mag_t'(-dot[2])
                                            : cahv_pkg::mag_t'(dot[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_ctl_reg <= '0;
        end else if (en) begin
            s5_ctl_reg <= s5_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= mag_a_next;
            num_x_reg <= {mag_h, 16'd0};
            num_y_reg <= {mag_v, 16'd0};
        end
    end

    cahv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (s5_ctl_reg),
        .num_x   (num_x_reg),
        .num_y   (num_y_reg),
        .den     (mag_a_reg),
        .out_ctl (div_ctl),
        .q_x     (q_x),
        .q_y     (q_y),
        .ovf_x   (ovf_x),
        .ovf_y   (ovf_y)
    );

    always_comb begin
        logic         sat_x, sat_y;
        logic [QW-1:0] x, y;
        sat_x = ovf_x || (div_ctl.neg_x ? (q_x > 32'h8000_0000) : q_x[QW-1]);
        sat_y = ovf_y || (div_ctl.neg_y ? (q_y > 32'h8000_0000) : q_y[QW-1]);
        if (div_ctl.neg_x) begin
            x = sat_x ? 32'h8000_0000 : QW'(32'd0 - q_x);
        end else begin
            x = sat_x ? 32'h7FFF_FFFF : q_x;
        end
        if (div_ctl.neg_y) begin
            y = sat_y ? 32'h8000_0000 : QW'(32'd0 - q_y);
        end else begin
            y = sat_y ? 32'h7FFF_FFFF : q_y;
        end
        if (div_ctl.ok) begin
            m_tdata_next = {y, x};
            m_tuser_next = {sat_x || sat_y, 1'b1};
        end else begin
            m_tdata_next = '0;
            m_tuser_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CAHV_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
        m_tdata == 64'd0 && !m_tuser[1], "Unprojected word carries nonzero fields.")
    `CAHV_ASSERT_NOW(a_sat_needs_valid, aclk, aresetn, m_tvalid && m_tuser[1],
        m_tuser[0], "Saturation flagged on an unprojected word.")
    `CAHV_ASSERT_NEXT(a_coef_write, aclk, aresetn,
        accept && s_tuser == cahv_pkg::CMD_LOAD && ld_idx < 4'(cahv_pkg::NCOEF),
        coef_reg[$past(ld_idx)] == $past(s_tdata[51:4]), "Coefficient load was lost.")

endmodule

### rtl/cahv_mul.sv
module cahv_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  cahv_pkg::ctl_t   in_ctl,
    input  cahv_pkg::dvec_t  d [3],
    input  cahv_pkg::coef_t  cf [9],
    output cahv_pkg::ctl_t   out_ctl,
    output cahv_pkg::dot_t   dot [3]
);

    cahv_pkg::ctl_t  ctl_a_reg, ctl_b_reg, ctl_c_reg;
    cahv_pkg::part_t pp_reg [9][4];
    cahv_pkg::part_t pp_next [9][4];
    cahv_pkg::dot_t  prod_reg [9];
    cahv_pkg::dot_t  prod_next [9];
    cahv_pkg::dot_t  dot_reg [3];
    cahv_pkg::dot_t  dot_next [3];

    always_comb begin
        logic        [cahv_pkg::CLW-1:0]          cl;
        logic signed [cahv_pkg::CW-cahv_pkg::CLW-1:0] ch;
        logic        [cahv_pkg::DLW-1:0]          dl;
        logic signed [cahv_pkg::DW-cahv_pkg::DLW-1:0] dh;
        for (int j = 0; j < 9; j++) begin
            cl = cf[j][cahv_pkg::CLW-1:0];
            ch = cf[j][cahv_pkg::CW-1:cahv_pkg::CLW];
            dl = d[j % 3][cahv_pkg::DLW-1:0];
            dh = d[j % 3][cahv_pkg::DW-1:cahv_pkg::DLW];
            pp_next[j][0] = cahv_pkg::PPW'($signed({1'b0, cl}) * $signed({1'b0, dl}));
            pp_next[j][1] = cahv_pkg::PPW'($signed({1'b0, cl}) * dh);
            pp_next[j][2] = cahv_pkg::PPW'(ch * $signed({1'b0, dl}));
            pp_next[j][3] = cahv_pkg::PPW'(ch * dh);
        end
    end

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            prod_next[j] = cahv_pkg::PW'(pp_reg[j][0])
                         + (cahv_pkg::PW'(pp_reg[j][1]) <<< cahv_pkg::DLW)
                         + (cahv_pkg::PW'(pp_reg[j][2]) <<< cahv_pkg::CLW)
                         + (cahv_pkg::PW'(pp_reg[j][3]) <<< (cahv_pkg::CLW + cahv_pkg::DLW));
        end
        for (int k = 0; k < 3; k++) begin
            dot_next[k] = prod_reg[3*k] + prod_reg[3*k+1] + prod_reg[3*k+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg   <= pp_next;
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
        end
    end

    assign out_ctl = ctl_c_reg;
    assign dot     = dot_reg;

endmodule

### rtl/cahv_div.sv
module cahv_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  cahv_pkg::div_ctl_t  in_ctl,
    input  cahv_pkg::num_t      num_x,
    input  cahv_pkg::num_t      num_y,
    input  cahv_pkg::mag_t      den,
    output cahv_pkg::div_ctl_t  out_ctl,
    output cahv_pkg::quo_t      q_x,
    output cahv_pkg::quo_t      q_y,
    output logic                ovf_x,
    output logic                ovf_y
);

    localparam int QW = cahv_pkg::QW;

    cahv_pkg::div_ctl_t ctl_reg [QW+1];
    cahv_pkg::mag_t     den_reg [QW+1];
    cahv_pkg::num_t     rx_reg  [QW+1];
    cahv_pkg::num_t     ry_reg  [QW+1];
    cahv_pkg::quo_t     qx_reg  [QW+1];
    cahv_pkg::quo_t     qy_reg  [QW+1];
    logic               ox_reg  [QW+1];
    logic               oy_reg  [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den;
            rx_reg[0]  <= num_x;
            ry_reg[0]  <= num_y;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            ox_reg[0]  <= {{(cahv_pkg::PW+QW-cahv_pkg::NW){1'b0}}, num_x[cahv_pkg::NW-1:QW]} >= den;
            oy_reg[0]  <= {{(cahv_pkg::PW+QW-cahv_pkg::NW){1'b0}}, num_y[cahv_pkg::NW-1:QW]} >= den;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [cahv_pkg::SW-1:0] dsh, ex, ey, dfx, dfy;
        logic                    gex, gey;

        always_comb begin
            dsh = {{QW{1'b0}}, den_reg[k-1]} << B;
            ex  = {{(cahv_pkg::SW-cahv_pkg::NW){1'b0}}, rx_reg[k-1]};
            ey  = {{(cahv_pkg::SW-cahv_pkg::NW){1'b0}}, ry_reg[k-1]};
            gex = ex >= dsh;
            gey = ey >= dsh;
            dfx = ex - dsh;
            dfy = ey - dsh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_reg[k-1];
                rx_reg[k]  <= gex ? dfx[cahv_pkg::NW-1:0] : rx_reg[k-1];
                ry_reg[k]  <= gey ? dfy[cahv_pkg::NW-1:0] : ry_reg[k-1];
                qx_reg[k]  <= qx_reg[k-1] | (QW'(gex) << B);
                qy_reg[k]  <= qy_reg[k-1] | (QW'(gey) << B);
                ox_reg[k]  <= ox_reg[k-1];
                oy_reg[k]  <= oy_reg[k-1];
            end
        end
    end

    assign out_ctl = ctl_reg[QW];
    assign q_x     = qx_reg[QW];
    assign q_y     = qy_reg[QW];
    assign ovf_x   = ox_reg[QW];
    assign ovf_y   = oy_reg[QW];

endmodule

### tb/cahv_point_projection_tb.sv
`timescale 1ns / 1ps

module cahv_point_projection_tb;

    typedef struct {
        logic [3:0]         coef_index;
        logic signed [47:0] coef_value;
        logic signed [39:0] northing;
        logic signed [39:0] easting;
        logic signed [31:0] elevation;
        logic signed [7:0]  fov_mask;
    } point_word_t;

    typedef struct {
        logic        valid_res;
        logic [31:0] image_x;
        logic [31:0] image_y;
        logic        saturated;
    } image_word_t;

    class projection_scoreboard;
        logic signed [47:0] camera[cahv_pkg::NCOEF];
        image_word_t        expected_images[$];
        int                 errors;

        function new();
            foreach (camera[i]) camera[i] = '0;
            errors = 0;
        endfunction

        function logic signed [127:0] dot3(int base, logic signed [127:0] d[3]);
            logic signed [127:0] acc;
            logic signed [127:0] c;
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                c = 128'(camera[base + i]);
                acc = acc + c * d[i];
            end
            return acc;
        endfunction

        function logic [31:0] scaled_quotient(logic signed [127:0] num,
                                              logic signed [127:0] den, ref logic sat);
            logic signed [159:0] n;
            logic signed [159:0] q;
            n = 160'(num);
            n = n <<< 16;
            q = n / 160'(den);
            if (q > 160'sd2147483647) begin
                sat = 1'b1;
                return 32'h7fffffff;
            end
            if (q < -160'sd2147483648) begin
                sat = 1'b1;
                return 32'h80000000;
            end
            return q[31:0];
        endfunction

        function void note_word(logic cmd, point_word_t w);
            image_word_t         e;
            logic signed [127:0] d[3];
            logic signed [127:0] ad, hd, vd;
            logic                sat;
            if (cmd == cahv_pkg::CMD_LOAD) begin
                if (w.coef_index < cahv_pkg::NCOEF) camera[w.coef_index] = w.coef_value;
                return;
            end
            e = '{1'b0, 32'd0, 32'd0, 1'b0};
            if (w.fov_mask > cahv_pkg::FOV_MIN) begin
                d[0] = (128'(w.northing) <<< 16) - 128'(camera[cahv_pkg::C_BASE]);
                d[1] = (128'(w.easting) <<< 16) - 128'(camera[cahv_pkg::C_BASE + 1]);
                d[2] = -(128'(w.elevation) <<< 16) - 128'(camera[cahv_pkg::C_BASE + 2]);
                ad = dot3(cahv_pkg::A_BASE, d);
                if (ad != 0) begin
                    hd = dot3(cahv_pkg::H_BASE, d);
                    vd = dot3(cahv_pkg::V_BASE, d);
                    sat = 1'b0;
                    e.image_x = scaled_quotient(hd, ad, sat);
                    e.image_y = scaled_quotient(vd, ad, sat);
                    e.valid_res = 1'b1;
                    e.saturated = sat;
                end
            end
            expected_images.push_back(e);
        endfunction

        function void check_word(image_word_t got);
            image_word_t e;
            if (expected_images.size() == 0) begin
                $error("unexpected result word x=%h y=%h", got.image_x, got.image_y);
                errors++;
                return;
            end
            e = expected_images.pop_front();
            if (got.valid_res !== e.valid_res) begin
                $error("valid_res expected %0b actual %0b", e.valid_res, got.valid_res);
                errors++;
            end
            if (got.image_x !== e.image_x) begin
                $error("image_x expected %h actual %h", e.image_x, got.image_x);
                errors++;
            end
            if (got.image_y !== e.image_y) begin
                $error("image_y expected %h actual %h", e.image_y, got.image_y);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $error("saturated expected %0b actual %0b", e.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return expected_images.size();
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    projection_scoreboard sb = new();
    int burst_left = 0;
    int sent = 0;
    int cycle_count = 0;
    int stall_mode = 0;

    cahv_point_projection dut (.*);

    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("cahv_point_projection verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        image_word_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) stall_mode <= int'($urandom_range(0, 2));
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            got.image_x = m_tdata[31:0];
            got.image_y = m_tdata[63:32];
            got.valid_res = m_tuser[0];
            got.saturated = m_tuser[1];
            sb.check_word(got);
        end
    end

    task automatic send_word(logic cmd, point_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, w.fov_mask, w.elevation, w.easting, w.northing,
                    w.coef_value, w.coef_index};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(cmd, w);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    function automatic point_word_t rand_word(bit wide);
        point_word_t w;
        w.coef_index = 4'($urandom_range(0, 15));
        w.coef_value = 48'({$urandom, $urandom});
        if (wide) begin
            w.northing = 40'({$urandom, $urandom});
            w.easting = 40'({$urandom, $urandom});
            w.elevation = $urandom;
            w.fov_mask = 8'($urandom);
        end else begin
            w.northing = 40'(signed'($urandom_range(0, 33554431)) - 16777216);
            w.easting = 40'(signed'($urandom_range(0, 33554431)) - 16777216);
            w.elevation = 32'(signed'($urandom_range(0, 33554431)) - 16777216);
            w.fov_mask = 8'($urandom_range(2, 127));
        end
        return w;
    endfunction

    task automatic load_coef(int idx, logic signed [47:0] v);
        point_word_t w;
        w = rand_word(1'b1);
        w.coef_index = 4'(idx);
        w.coef_value = v;
        send_word(cahv_pkg::CMD_LOAD, w);
    endtask

    task automatic project(logic signed [39:0] n, logic signed [39:0] e,
                           logic signed [31:0] z, logic signed [7:0] mask);
        point_word_t w;
        w = rand_word(1'b1);
        w.northing = n;
        w.easting = e;
        w.elevation = z;
        w.fov_mask = mask;
        send_word(cahv_pkg::CMD_PROJECT, w);
    endtask

    initial begin
        logic signed [47:0] one;
        point_word_t        w;
        int                 r;
        one = 48'sd1 <<< 32;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        project(40'sd65536, 40'sd65536, 32'sd65536, 8'sd2);
        load_coef(cahv_pkg::A_BASE + 2, -one);
        load_coef(cahv_pkg::H_BASE, one);
        load_coef(cahv_pkg::V_BASE + 1, one);
        load_coef(13, one);
        project(40'sd65536, -40'sd131072, -32'sd655360, 8'sd127);
        project(40'sd65536, 40'sd65536, 32'sd0, 8'sd5);
        project(40'sd65536, 40'sd65536, -32'sd65536, 8'sd1);
        project(40'sd65536, 40'sd65536, -32'sd65536, 8'sd0);
        project(40'sd65536, 40'sd65536, -32'sd65536, -8'sd128);
        project(40'sh7fffffffff, 40'sh8000000000, -32'sd1, 8'sd2);
        project(40'sh8000000000, 40'sh7fffffffff, 32'sh7fffffff, 8'sd3);
        project(40'sd1, -40'sd1, 32'sh80000000, 8'sd127);
        load_coef(cahv_pkg::C_BASE, 48'sh7fffffffffff);
        load_coef(cahv_pkg::C_BASE + 1, 48'sh800000000000);
        load_coef(cahv_pkg::C_BASE + 2, one);
        load_coef(cahv_pkg::A_BASE, 48'sh800000000000);
        load_coef(cahv_pkg::A_BASE + 1, 48'sh7fffffffffff);
        load_coef(cahv_pkg::H_BASE + 1, 48'sh7fffffffffff);
        load_coef(cahv_pkg::H_BASE + 2, 48'sh800000000000);
        load_coef(cahv_pkg::V_BASE, 48'sh800000000000);
        load_coef(cahv_pkg::V_BASE + 2, 48'sh7fffffffffff);
        project(40'sh7fffffffff, 40'sh7fffffffff, 32'sh80000000, 8'sd127);
        project(40'sh8000000000, 40'sd0, 32'sh7fffffff, 8'sd2);
        drain_results();

        while (sent < 1650) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                for (int i = 0; i < cahv_pkg::NCOEF; i++) begin
                    if ($urandom_range(0, 7) == 0) load_coef(i, 48'({$urandom, $urandom}));
                    else load_coef(i, 48'(signed'($urandom)) <<< 1);
                end
            end else if (r < 13) begin
                send_word(cahv_pkg::CMD_LOAD, rand_word(1'b1));
            end else if (r < 25) begin
                send_word(cahv_pkg::CMD_PROJECT, rand_word(1'b1));
            end else begin
                send_word(cahv_pkg::CMD_PROJECT, rand_word(1'b0));
            end
            if (sent > 800 && sent < 830 && r == 50) drain_results();
        end
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("cahv_point_projection verification clean");
        end else begin
            if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
            $display("cahv_point_projection verification failed");
        end
        $finish;
    end
endmodule

### cahv_point_projection.f
+incdir+rtl
rtl/cahv_pkg.sv
rtl/cahv_mul.sv
rtl/cahv_div.sv
rtl/cahv_point_projection.sv
tb/cahv_point_projection_tb.sv
